// ----- rtl/b62kbh_pkg.sv -----
package b62kbh_pkg;

  localparam int unsigned AccW   = 64;
  localparam int unsigned SizeW  = 32;
  localparam int unsigned CharW  = 8;
  localparam int unsigned DigitW = 6;

  localparam logic [CharW-1:0]  CharLowA  = 8'h61;  // 'a'
  localparam logic [CharW-1:0]  CharLowZ  = 8'h7a;  // 'z'
  localparam logic [CharW-1:0]  CharUpA   = 8'h41;  // 'A'
  localparam logic [CharW-1:0]  CharUpZ   = 8'h5a;  // 'Z'
  localparam logic [CharW-1:0]  CharZero  = 8'h30;  // '0'
  localparam logic [CharW-1:0]  CharNine  = 8'h39;  // '9'
  localparam logic [DigitW-1:0] LowerBase = 6'd10;
  localparam logic [DigitW-1:0] UpperBase = 6'd36;

  typedef struct packed {
    logic              ok;
    logic [DigitW-1:0] value;
  } digit_t;

  typedef struct packed {
    logic step;
    logic clear;
  } accum_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABSORB,
    ST_FINISH,
    ST_DIVIDE,
    ST_RESULT
  } state_t;

  function automatic digit_t digit_of(input logic [CharW-1:0] c);
    digit_t d;
    d.ok    = 1'b1;
    d.value = '0;
    if (c >= CharLowA && c <= CharLowZ) begin
      d.value = DigitW'(c - CharLowA) + LowerBase;
    end else if (c >= CharUpA && c <= CharUpZ) begin
      d.value = DigitW'(c - CharUpA) + UpperBase;
    end else if (c >= CharZero && c <= CharNine) begin
      d.value = DigitW'(c - CharZero);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

// ----- rtl/b62kbh_accum.sv -----
module b62kbh_accum
  import b62kbh_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  accum_ctrl_t      ctrl,
  input  logic [CharW-1:0] key_char,
  output logic [AccW-1:0]  acc,
  output logic             err
);

  localparam int unsigned ProdW = AccW + DigitW;

  digit_t           dig;
  logic [ProdW-1:0] prod;
  logic [ProdW-1:0] sum;
  logic             ovf;

  // acc*62 = acc*64 - acc*2; result always fits in ProdW bits
  always_comb begin
    dig  = digit_of(key_char);
    prod = {acc, {DigitW{1'b0}}} - ProdW'({acc, 1'b0});
    sum  = prod + ProdW'(dig.value);
    ovf  = |sum[ProdW-1:AccW];
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      acc <= '0;
      err <= 1'b0;
    end else if (ctrl.step && !err) begin
      if (!dig.ok || ovf) begin
        err <= 1'b1;
      end else begin
        acc <= sum[AccW-1:0];
      end
    end
  end

endmodule

// ----- rtl/b62kbh_divider.sv -----
module b62kbh_divider
  import b62kbh_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AccW-1:0]  dividend,
  input  logic [SizeW-1:0] divisor,
  output logic             done,
  output logic [SizeW-1:0] remainder
);

  localparam int unsigned CountW = $clog2(AccW);
  localparam logic [CountW-1:0] LastCount = CountW'(AccW - 1);

  logic              busy;
  logic [CountW-1:0] count;
  logic [AccW-1:0]   quot;
  logic [SizeW:0]    trial;
  logic [SizeW+1:0]  diff;
  logic [SizeW-1:0]  remainder_next;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    trial          = {remainder, quot[AccW-1]};
    diff           = {1'b0, trial} - {2'b00, divisor};
    remainder_next = diff[SizeW+1] ? trial[SizeW-1:0] : diff[SizeW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == LastCount) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      count     <= '0;
      quot      <= dividend;
      remainder <= '0;
    end else if (busy) begin
      count     <= count + 1'b1;
      quot      <= {quot[AccW-2:0], 1'b0};
      remainder <= remainder_next;
    end
  end

endmodule

// ----- rtl/base62_key_bucket_hash.sv -----
// Base-62 key hash. Key characters arrive one per transaction, last character
// first, with last_char set on the first character of the key. Each character
// is captured, then accumulated (multiply-by-62 and add). After the final
// character a finish step starts a restoring divider that forms the remainder
// by table_size at one bit per cycle; the remainder is captured, then loaded
// into the output register when it is empty or not stalled. An invalid
// character or 64-bit overflow yields status 1 with bucket_index 0 and skips
// the divide, as does table_size 0 (status 0, bucket_index 0). table_size
// resets to 1 and may only be written while no key is in progress; cfg_ready
// is always high.
module base62_key_bucket_hash
  import b62kbh_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CharW-1:0] key_char,
  input  logic             last_char,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [SizeW-1:0] bucket_index,
  output logic             status,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [SizeW-1:0] table_size
);

  state_t           state;
  state_t           state_next;
  logic [SizeW-1:0] size_reg;
  logic [CharW-1:0] char_q;
  logic             last_q;
  logic [SizeW-1:0] res_index;
  logic             res_status;

  accum_ctrl_t      acc_ctrl;
  logic [AccW-1:0]  acc;
  logic             err;
  logic             div_start;
  logic             div_done;
  logic [SizeW-1:0] div_rem;
  logic             direct_result;
  logic             out_load;
  logic             in_take;

  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && !in_stall;

  b62kbh_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (acc_ctrl),
    .key_char (char_q),
    .acc      (acc),
    .err      (err)
  );

  b62kbh_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (acc),
    .divisor   (size_reg),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_ABSORB;
      ST_ABSORB: state_next = last_q ? ST_FINISH : ST_IDLE;
      ST_FINISH: state_next = (err || size_reg == '0) ? ST_RESULT : ST_DIVIDE;
      ST_DIVIDE: if (div_done) state_next = ST_RESULT;
      ST_RESULT: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = 1'b1;
    acc_ctrl.step  = 1'b0;
    acc_ctrl.clear = 1'b0;
    div_start      = 1'b0;
    direct_result  = 1'b0;
    out_load       = 1'b0;
    unique case (state)
      ST_IDLE:   in_stall = 1'b0;
      ST_ABSORB: acc_ctrl.step = 1'b1;
      ST_FINISH: begin
        // divider latches acc this edge, so the clear is safe
        acc_ctrl.clear = 1'b1;
        direct_result  = err || size_reg == '0;
        div_start      = !direct_result;
      end
      ST_DIVIDE: ;
      ST_RESULT: out_load = !out_valid || !out_stall;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      size_reg  <= SizeW'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        size_reg <= table_size;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      char_q <= key_char;
      last_q <= last_char;
    end
    if (direct_result) begin
      res_index  <= '0;
      res_status <= err;
    end else if (div_done) begin
      res_index  <= div_rem;
      res_status <= 1'b0;
    end
    if (out_load) begin
      bucket_index <= res_index;
      status       <= res_status;
    end
  end

endmodule
